@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define CHK_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define CHK_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/fnc_pkg.sv @@
package fnc_pkg;

  localparam int TRACK_BYTES = 6656;
  localparam int TRACK_COUNT = 35;
  localparam int SPIN_TIMEOUT = 20000;
  localparam int DRIVE_COUNT = 2;
  localparam int MAX_HALF_TRACK = 79;

  localparam int IDX_W = 13;
  localparam int ADDR_W = 14;
  localparam int CNT_W = 15;

  typedef enum logic [1:0] {
    CMD_SWITCH = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_LOAD   = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    CFG_LOADED0    = 3'd0,
    CFG_LOADED1    = 3'd1,
    CFG_PROTECTED0 = 3'd2,
    CFG_PROTECTED1 = 3'd3,
    CFG_ENHANCED   = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ROT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic rot_step;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic rot_busy;
  } dp_stat_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  addr_low;
    logic        is_write;
    logic [7:0]  bus_data;
    logic [15:0] elapsed_cycles;
    logic        target_drive;
    logic [12:0] nibble_index;
    logic [7:0]  nibble_data;
    logic        last_nibble;
    logic [7:0]  floating_value;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       current_drive;
    logic [6:0] half_track;
    logic [5:0] track;
    logic       track_needed;
    logic       writeback_needed;
    logic       motor_on;
    logic [1:0] spinning_mask;
    logic [1:0] writing_mask;
  } result_t;

endpackage

@@ rtl/fnc_ctrl.sv @@
module fnc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic                out_busy,
  input  fnc_pkg::dp_stat_t   stat,
  output fnc_pkg::ctl_cmd_t   ctl,
  output logic                in_ready,
  output logic                idle
);
  import fnc_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl = '0;
    in_ready = 1'b0;
    idle = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        idle = 1'b1;
        if (in_fire) begin
          ctl.capture = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ctl.exec = 1'b1;
        state_nxt = ST_ROT;
      end
      ST_ROT: begin
        // Modulo reduction of the rotated byte position, one subtract a cycle.
        if (stat.rot_busy) begin
          ctl.rot_step = 1'b1;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_busy) begin
          ctl.out_load = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

@@ rtl/fnc_datapath.sv @@
module fnc_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  fnc_pkg::ctl_cmd_t  ctl,
  input  fnc_pkg::item_t     item,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic               cfg_val,
  output fnc_pkg::dp_stat_t  stat,
  output fnc_pkg::result_t   res
);
  import fnc_pkg::*;

  item_t it_r;

  logic [1:0] loaded_r, prot_r;
  logic       enh_r;
  logic [3:0] phases_r;
  logic       sel_r, motor_r, wmode_r, acc_r;
  logic [7:0] latch_r;
  logic [5:0] spin_acc_r;
  logic [4:0] rot_acc_r;
  logic [6:0] head_r [DRIVE_COUNT];
  logic [IDX_W:0] bpos_r [DRIVE_COUNT];
  logic [IDX_W-1:0] ncnt_r [DRIVE_COUNT];
  logic [1:0] valid_r, dirty_r;
  logic [CNT_W-1:0] spin_r [DRIVE_COUNT];
  logic [CNT_W-1:0] wl_r [DRIVE_COUNT];
  logic [7:0] store [DRIVE_COUNT*TRACK_BYTES];
  logic [7:0] rdata_r;
  logic [7:0] rd_r;
  logic       use_mem_r;
  logic [10:0] spin_t;
  logic [11:0] rot_t;

  // Rotation modulo runs over both drives during the reduce state.
  logic [1:0] rot_pend_r;
  assign stat.rot_busy = |rot_pend_r;

  function automatic logic [ADDR_W-1:0] mk_addr(input logic d, input logic [IDX_W-1:0] i);
    logic [ADDR_W-1:0] b;
    b = d ? ADDR_W'(TRACK_BYTES) : '0;
    return b + ADDR_W'(i);
  endfunction

  always_ff @(posedge clk) begin
    if (ctl.capture) it_r <= item;
  end

  logic d;
  logic [3:0] ph_n;
  logic [6:0] hp, hn;
  logic dir_p, dir_m;
  logic [IDX_W:0] bp;
  logic [IDX_W:0] bp1;
  logic [21:0] sum_s, sum_r2;

  always_comb begin
    d = sel_r;
    ph_n = phases_r;
    if (it_r.addr_low[0]) ph_n[it_r.addr_low[2:1]] = 1'b1;
    else ph_n[it_r.addr_low[2:1]] = 1'b0;
    hp = head_r[d];
    dir_p = ph_n[2'(hp + 7'd1)];
    dir_m = ph_n[2'(hp + 7'd3)];
    hn = hp;
    if (dir_p && !dir_m && hp < 7'(MAX_HALF_TRACK)) hn = hp + 7'd1;
    if (dir_m && !dir_p && hp > 7'd0) hn = hp - 7'd1;
    bp = bpos_r[d];
    if (bp >= {1'b0, ncnt_r[d]} || bp >= (IDX_W+1)'(TRACK_BYTES)) bp = '0;
    bp1 = bp + 1'b1;
    if (bp1 >= {1'b0, ncnt_r[d]}) bp1 = '0;
    sum_s = 22'(spin_acc_r) + 22'(it_r.elapsed_cycles);
    sum_r2 = 22'(rot_acc_r) + 22'(it_r.elapsed_cycles);
    spin_t = sum_s[16:6];
    rot_t = sum_r2[16:5];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r <= '0; prot_r <= '0; enh_r <= 1'b1;
      phases_r <= '0; sel_r <= 1'b0; motor_r <= 1'b0; wmode_r <= 1'b0;
      acc_r <= 1'b0; latch_r <= '0; spin_acc_r <= '0; rot_acc_r <= '0;
      valid_r <= '0; dirty_r <= '0; rot_pend_r <= '0;
      use_mem_r <= 1'b0; rd_r <= '0;
      for (int k = 0; k < DRIVE_COUNT; k++) begin
        head_r[k] <= '0; bpos_r[k] <= '0; ncnt_r[k] <= '0;
        spin_r[k] <= '0; wl_r[k] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_LOADED0, CFG_LOADED1: begin
            loaded_r[cfg_idx[0]] <= cfg_val;
            if (!cfg_val) begin
              valid_r[cfg_idx[0]] <= 1'b0;
              dirty_r[cfg_idx[0]] <= 1'b0;
            end
          end
          CFG_PROTECTED0, CFG_PROTECTED1: prot_r[cfg_idx[0]] <= cfg_val;
          CFG_ENHANCED: enh_r <= cfg_val;
          default: ;
        endcase
      end
      if (ctl.rot_step) begin
        for (int k = 0; k < DRIVE_COUNT; k++) begin
          if (rot_pend_r[k]) begin
            if (ncnt_r[k] == '0) begin
              bpos_r[k] <= '0; rot_pend_r[k] <= 1'b0;
            end else if (bpos_r[k] >= {1'b0, ncnt_r[k]}) begin
              bpos_r[k] <= bpos_r[k] - {1'b0, ncnt_r[k]};
            end else begin
              rot_pend_r[k] <= 1'b0;
            end
          end
        end
      end
      if (ctl.exec) begin
        use_mem_r <= 1'b0;
        rd_r <= '0;
        case (cmd_t'(it_r.command))
          CMD_SWITCH: begin
            case (it_r.addr_low[3:0])
              4'h8, 4'h9: begin
                motor_r <= it_r.addr_low[0];
                if (it_r.addr_low[0]) spin_r[d] <= CNT_W'(SPIN_TIMEOUT);
                rd_r <= {1'b1, it_r.floating_value[6:0]};
              end
              4'hA, 4'hB: begin
                sel_r <= it_r.addr_low[0];
                spin_r[~it_r.addr_low[0]] <= '0;
                wl_r[~it_r.addr_low[0]] <= '0;
                if (motor_r) spin_r[it_r.addr_low[0]] <= CNT_W'(SPIN_TIMEOUT);
              end
              4'hC: begin
                acc_r <= 1'b1;
                if (!valid_r[d] || ncnt_r[d] == '0) begin
                  rd_r <= 8'hFF;
                end else if (wmode_r && !latch_r[7] && !prot_r[d]) begin
                  bpos_r[d] <= bp;
                end else begin
                  bpos_r[d] <= bp1;
                  if (wmode_r) begin
                    if (!prot_r[d]) begin
                      store[mk_addr(d, bp[IDX_W-1:0])] <= latch_r;
                      dirty_r[d] <= 1'b1;
                    end
                  end else begin
                    use_mem_r <= 1'b1;
                  end
                end
              end
              4'hD: begin
                if (it_r.is_write) latch_r <= it_r.bus_data;
                rd_r <= it_r.is_write ? it_r.bus_data : latch_r;
              end
              4'hE: begin
                wmode_r <= 1'b0;
                rd_r <= {prot_r[d], it_r.floating_value[6:0]};
              end
              4'hF: begin
                wmode_r <= 1'b1;
                wl_r[d] <= CNT_W'(SPIN_TIMEOUT);
                rd_r <= {1'b1, it_r.floating_value[6:0]};
              end
              default: begin
                phases_r <= ph_n;
                head_r[d] <= hn;
                if (hn != hp) begin
                  valid_r[d] <= 1'b0;
                  if (prot_r[d]) dirty_r[d] <= 1'b0;
                end
                rd_r <= (it_r.addr_low == 8'hE0) ? 8'hFF
                        : {1'b1, it_r.floating_value[6:0]};
              end
            endcase
          end
          CMD_TICK: begin
            spin_acc_r <= sum_s[5:0];
            rot_acc_r <= sum_r2[4:0];
            acc_r <= 1'b0;
            for (int k = 0; k < DRIVE_COUNT; k++) begin
              logic [CNT_W-1:0] sc;
              sc = spin_r[k];
              if (spin_r[k] != '0 && !motor_r)
                sc = ({4'd0, spin_t} >= spin_r[k]) ? '0 : spin_r[k] - CNT_W'(spin_t);
              spin_r[k] <= sc;
              // The write light and rotation both see the counter after this tick.
              if (wmode_r && sel_r == k[0] && sc != '0)
                wl_r[k] <= CNT_W'(SPIN_TIMEOUT);
              else if (wl_r[k] != '0)
                wl_r[k] <= ({4'd0, spin_t} >= wl_r[k]) ? '0 : wl_r[k] - CNT_W'(spin_t);
              if (!enh_r && !acc_r && sc != '0) begin
                bpos_r[k] <= bpos_r[k] + (IDX_W+1)'(rot_t);
                rot_pend_r[k] <= 1'b1;
              end
            end
          end
          CMD_LOAD: begin
            if (loaded_r[it_r.target_drive] && !dirty_r[it_r.target_drive]
                && it_r.nibble_index < IDX_W'(TRACK_BYTES)) begin
              store[mk_addr(it_r.target_drive, it_r.nibble_index)] <= it_r.nibble_data;
              if (it_r.last_nibble) begin
                ncnt_r[it_r.target_drive] <= it_r.nibble_index + 1'b1;
                valid_r[it_r.target_drive] <= 1'b1;
                bpos_r[it_r.target_drive] <= '0;
              end
            end
          end
          default: begin
            if (it_r.nibble_index < IDX_W'(TRACK_BYTES)) use_mem_r <= 1'b1;
            if (it_r.last_nibble) dirty_r[it_r.target_drive] <= 1'b0;
          end
        endcase
      end
    end
  end

  // Registered store read port, addressed from the captured item.
  logic [ADDR_W-1:0] raddr;
  always_comb begin
    if (cmd_t'(it_r.command) == CMD_SWITCH) raddr = mk_addr(d, bp[IDX_W-1:0]);
    else raddr = mk_addr(it_r.target_drive, it_r.nibble_index);
  end
  always_ff @(posedge clk) begin
    if (ctl.exec) rdata_r <= store[raddr];
  end

  logic [6:0] ht;
  logic [5:0] trk;
  always_comb begin
    ht = head_r[sel_r];
    trk = (ht[6:1] > 6'(TRACK_COUNT-1)) ? 6'(TRACK_COUNT-1) : ht[6:1];
    res.read_data = use_mem_r ? rdata_r : rd_r;
    res.current_drive = sel_r;
    res.half_track = ht;
    res.track = trk;
    res.track_needed = loaded_r[sel_r] && !valid_r[sel_r];
    res.writeback_needed = dirty_r[sel_r] && !valid_r[sel_r];
    res.motor_on = motor_r;
    res.spinning_mask = {spin_r[1] != '0, spin_r[0] != '0};
    res.writing_mask = {wl_r[1] != '0, wl_r[0] != '0};
  end
endmodule

@@ rtl/floppy_nibble_controller.sv @@
// Each request runs through the capture, execute, reduce and output states of
// the controller. After a rotating tick the reduce state subtracts the track
// length until the position is in range; the output state waits while a held
// result would be overwritten. One request at a time: a new one is accepted
// only back in the idle state.
// Reset (synchronous, rst_n low) clears all control state, sets enhanced_timing, holds off input.
`include "assert_macros.svh"
module floppy_nibble_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_addr_low,
  input  logic        in_is_write,
  input  logic [7:0]  in_bus_data,
  input  logic [15:0] in_elapsed_cycles,
  input  logic        in_target_drive,
  input  logic [12:0] in_nibble_index,
  input  logic [7:0]  in_nibble_data,
  input  logic        in_last_nibble,
  input  logic [7:0]  in_floating_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  output logic        out_current_drive,
  output logic [6:0]  out_half_track,
  output logic [5:0]  out_track,
  output logic        out_track_needed,
  output logic        out_writeback_needed,
  output logic        out_motor_on,
  output logic [1:0]  out_spinning_mask,
  output logic [1:0]  out_writing_mask,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic        cfg_data
);
  import fnc_pkg::*;

  ctl_cmd_t ctl;
  dp_stat_t stat;
  item_t    item;
  result_t  res, res_r;
  logic     in_ready, idle, in_fire, out_valid_r;

  // The result register holds a finished request while the consumer stalls.
  // Requests and register writes are refused while reset is held.
  assign in_stall = !in_ready || !rst_n;
  assign in_fire = in_valid && !in_stall;
  assign cfg_ready = rst_n;

  assign item = '{command: in_command, addr_low: in_addr_low, is_write: in_is_write,
                  bus_data: in_bus_data, elapsed_cycles: in_elapsed_cycles,
                  target_drive: in_target_drive, nibble_index: in_nibble_index,
                  nibble_data: in_nibble_data, last_nibble: in_last_nibble,
                  floating_value: in_floating_value};

  fnc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire),
    .out_busy(out_valid_r && out_stall), .stat(stat), .ctl(ctl),
    .in_ready(in_ready), .idle(idle)
  );

  fnc_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .item(item),
    .cfg_we(cfg_valid && cfg_ready), .cfg_idx(cfg_index), .cfg_val(cfg_data),
    .stat(stat), .res(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (ctl.out_load) res_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_read_data = res_r.read_data;
  assign out_current_drive = res_r.current_drive;
  assign out_half_track = res_r.half_track;
  assign out_track = res_r.track;
  assign out_track_needed = res_r.track_needed;
  assign out_writeback_needed = res_r.writeback_needed;
  assign out_motor_on = res_r.motor_on;
  assign out_spinning_mask = res_r.spinning_mask;
  assign out_writing_mask = res_r.writing_mask;

  `CHK_IMPL(a_load_not_stalled, clk, rst_n, ctl.out_load, !(out_valid_r && out_stall), "result overwritten")
  `CHK_NEXT(a_exec_after_capture, clk, rst_n, ctl.capture, ctl.exec, "execute did not follow capture")
  `CHK_IMPL(a_one_cmd, clk, rst_n, 1'b1, $onehot0({ctl.capture, ctl.exec, ctl.rot_step, ctl.out_load}), "overlapping commands")
  `CHK_IMPL(a_idle_ready, clk, rst_n, idle, in_ready, "idle but stalled")
endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the two-drive floppy nibble controller.
// An initial block builds the request stream: a short directed part that
// hits the corner cases, then phases of random traffic under different
// register settings. Every request is paired with the result that the
// bench's own controller model predicts for it. A clocked driver offers the
// requests, and a clocked monitor compares each returned result, field by
// field, with the oldest prediction still waiting.
module testbench;
  import fnc_pkg::*;

  // Soft switch codes, taken from address bits 3..0.
  localparam logic [3:0] SW_MOTOR_OFF  = 4'h8;
  localparam logic [3:0] SW_MOTOR_ON   = 4'h9;
  localparam logic [3:0] SW_SELECT0    = 4'hA;
  localparam logic [3:0] SW_SELECT1    = 4'hB;
  localparam logic [3:0] SW_NIBBLE     = 4'hC;
  localparam logic [3:0] SW_LATCH      = 4'hD;
  localparam logic [3:0] SW_READ_MODE  = 4'hE;
  localparam logic [3:0] SW_WRITE_MODE = 4'hF;
  localparam logic [7:0] STEPPER_E0    = 8'hE0;
  localparam int STORE_SIZE = DRIVE_COUNT * TRACK_BYTES;

  typedef struct {
    item_t   req;
    result_t res;
  } request_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  item_t       in_req = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  wire result_t out_res;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic        cfg_data = 1'b0;

  floppy_nibble_controller DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_command(in_req.command),
    .in_addr_low(in_req.addr_low),
    .in_is_write(in_req.is_write),
    .in_bus_data(in_req.bus_data),
    .in_elapsed_cycles(in_req.elapsed_cycles),
    .in_target_drive(in_req.target_drive),
    .in_nibble_index(in_req.nibble_index),
    .in_nibble_data(in_req.nibble_data),
    .in_last_nibble(in_req.last_nibble),
    .in_floating_value(in_req.floating_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_read_data(out_res.read_data),
    .out_current_drive(out_res.current_drive),
    .out_half_track(out_res.half_track),
    .out_track(out_res.track),
    .out_track_needed(out_res.track_needed),
    .out_writeback_needed(out_res.writeback_needed),
    .out_motor_on(out_res.motor_on),
    .out_spinning_mask(out_res.spinning_mask),
    .out_writing_mask(out_res.writing_mask),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Controller model. It mirrors the state of the block, including the
  // track store, and also remembers which store entries were ever written
  // so that the stimulus never reads one that was not.
  // ---------------------------------------------------------------------
  bit          m_loaded [DRIVE_COUNT];
  bit          m_protected [DRIVE_COUNT];
  bit          m_enhanced;
  bit [3:0]    m_phases;
  int unsigned m_sel;
  bit          m_motor;
  bit          m_write_mode;
  bit [7:0]    m_latch;
  bit          m_accessed;
  int unsigned m_spin_acc;
  int unsigned m_rot_acc;
  int unsigned m_head [DRIVE_COUNT];
  int unsigned m_pos [DRIVE_COUNT];
  int unsigned m_count [DRIVE_COUNT];
  bit          m_valid [DRIVE_COUNT];
  bit          m_dirty [DRIVE_COUNT];
  int unsigned m_spin [DRIVE_COUNT];
  int unsigned m_light [DRIVE_COUNT];
  bit [7:0]    m_store [STORE_SIZE];
  bit          m_written [STORE_SIZE];

  function automatic bit [7:0] float_byte(bit [7:0] fl, bit high);
    return {high, fl[6:0]};
  endfunction

  function automatic void spin_up();
    if (m_motor) m_spin[m_sel] = SPIN_TIMEOUT;
  endfunction

  function automatic bit [7:0] stepper_access(bit [7:0] addr, bit [7:0] fl);
    int unsigned d;
    int unsigned old_pos;
    int unsigned new_pos;
    int dir;
    bit [3:0] mask;
    d = m_sel;
    dir = 0;
    mask = 4'b1 << addr[2:1];
    if (addr[0]) m_phases |= mask;
    else m_phases &= ~mask;
    if (m_phases[(m_head[d] + 1) % 4]) dir += 1;
    if (m_phases[(m_head[d] + 3) % 4]) dir -= 1;
    if (dir != 0) begin
      old_pos = m_head[d];
      new_pos = old_pos;
      if (dir > 0 && old_pos < MAX_HALF_TRACK) new_pos = old_pos + 1;
      if (dir < 0 && old_pos > 0) new_pos = old_pos - 1;
      m_head[d] = new_pos;
      if (new_pos != old_pos) begin
        // A protected drive cannot have been changed, so its dirty mark goes.
        if (m_dirty[d] && m_protected[d]) m_dirty[d] = 0;
        m_valid[d] = 0;
      end
    end
    return (addr == STEPPER_E0) ? 8'hFF : float_byte(fl, 1'b1);
  endfunction

  function automatic bit [7:0] nibble_access();
    int unsigned d;
    int unsigned slot;
    bit [7:0] data;
    d = m_sel;
    data = 8'h00;
    m_accessed = 1;
    if (!m_valid[d] || m_count[d] == 0) return 8'hFF;
    if (m_pos[d] >= m_count[d] || m_pos[d] >= TRACK_BYTES) m_pos[d] = 0;
    slot = d * TRACK_BYTES + m_pos[d];
    if (!m_write_mode || !m_protected[d]) begin
      if (m_write_mode) begin
        if (!m_latch[7]) return 8'h00;
        m_store[slot] = m_latch;
        m_written[slot] = 1;
        m_dirty[d] = 1;
      end else begin
        data = m_store[slot];
      end
    end
    m_pos[d]++;
    if (m_pos[d] >= m_count[d]) m_pos[d] = 0;
    return data;
  endfunction

  function automatic bit [7:0] switch_access(item_t it);
    case (it.addr_low[3:0])
      SW_MOTOR_OFF, SW_MOTOR_ON: begin
        m_motor = it.addr_low[0];
        spin_up();
        return float_byte(it.floating_value, 1'b1);
      end
      SW_SELECT0, SW_SELECT1: begin
        m_sel = it.addr_low[0];
        m_spin[m_sel ^ 1] = 0;
        m_light[m_sel ^ 1] = 0;
        spin_up();
        return 8'h00;
      end
      SW_NIBBLE: return nibble_access();
      SW_LATCH: begin
        if (it.is_write) m_latch = it.bus_data;
        return m_latch;
      end
      SW_READ_MODE: begin
        m_write_mode = 0;
        return float_byte(it.floating_value, m_protected[m_sel]);
      end
      SW_WRITE_MODE: begin
        m_write_mode = 1;
        m_light[m_sel] = SPIN_TIMEOUT;
        return float_byte(it.floating_value, 1'b1);
      end
      default: return stepper_access(it.addr_low, it.floating_value);
    endcase
  endfunction

  function automatic void time_tick(int unsigned cycles);
    int unsigned spin_steps;
    int unsigned rot_ticks;
    m_spin_acc += cycles;
    spin_steps = m_spin_acc >> 6;
    m_spin_acc &= 63;
    m_rot_acc += cycles;
    rot_ticks = m_rot_acc >> 5;
    m_rot_acc &= 31;
    for (int d = 0; d < DRIVE_COUNT; d++) begin
      if (m_spin[d] != 0 && !m_motor)
        m_spin[d] = (spin_steps >= m_spin[d]) ? 0 : m_spin[d] - spin_steps;
      if (m_write_mode && m_sel == d && m_spin[d] != 0)
        m_light[d] = SPIN_TIMEOUT;
      else if (m_light[d] != 0)
        m_light[d] = (spin_steps >= m_light[d]) ? 0 : m_light[d] - spin_steps;
      // Without enhanced timing the disk turns under the head while idle.
      if (!m_enhanced && !m_accessed && m_spin[d] != 0) begin
        m_pos[d] += rot_ticks;
        if (m_pos[d] >= m_count[d])
          m_pos[d] = (m_count[d] != 0) ? m_pos[d] % m_count[d] : 0;
      end
    end
    m_accessed = 0;
  endfunction

  function automatic result_t controller_step(item_t it);
    result_t r;
    int unsigned slot;
    int unsigned d;
    r = '0;
    slot = it.target_drive * TRACK_BYTES + it.nibble_index;
    case (it.command)
      CMD_SWITCH: r.read_data = switch_access(it);
      CMD_TICK: time_tick(it.elapsed_cycles);
      CMD_LOAD: begin
        if (m_loaded[it.target_drive] && !m_dirty[it.target_drive] &&
            it.nibble_index < TRACK_BYTES) begin
          m_store[slot] = it.nibble_data;
          m_written[slot] = 1;
          if (it.last_nibble) begin
            m_count[it.target_drive] = it.nibble_index + 1;
            m_valid[it.target_drive] = 1;
            m_pos[it.target_drive] = 0;
          end
        end
      end
      default: begin
        if (it.nibble_index < TRACK_BYTES) r.read_data = m_store[slot];
        if (it.last_nibble) m_dirty[it.target_drive] = 0;
      end
    endcase
    d = m_sel;
    r.current_drive = d[0];
    r.half_track = 7'(m_head[d]);
    r.track = 6'(((m_head[d] >> 1) > TRACK_COUNT - 1) ? TRACK_COUNT - 1 : m_head[d] >> 1);
    r.track_needed = m_loaded[d] && !m_valid[d];
    r.writeback_needed = m_dirty[d] && !m_valid[d];
    r.motor_on = m_motor;
    r.spinning_mask = {m_spin[1] != 0, m_spin[0] != 0};
    r.writing_mask = {m_light[1] != 0, m_light[0] != 0};
    return r;
  endfunction

  // True when the request would read a store entry that was never written.
  function automatic bit hits_blank_entry(item_t it);
    int unsigned d;
    int unsigned p;
    if (it.command == CMD_READ)
      return it.nibble_index < TRACK_BYTES &&
             !m_written[it.target_drive * TRACK_BYTES + it.nibble_index];
    if (it.command != CMD_SWITCH || it.addr_low[3:0] != SW_NIBBLE) return 0;
    d = m_sel;
    if (!m_valid[d] || m_count[d] == 0 || m_write_mode) return 0;
    p = (m_pos[d] >= m_count[d] || m_pos[d] >= TRACK_BYTES) ? 0 : m_pos[d];
    return !m_written[d * TRACK_BYTES + p];
  endfunction

  // ---------------------------------------------------------------------
  // Request and prediction queues, counters shared by the processes.
  // ---------------------------------------------------------------------
  request_t pending_reqs[$];
  result_t  predicted[$];
  request_t cur_req;
  bit       req_taken = 0;
  int       errors = 0;
  int       results_checked = 0;
  int       settings_run = 0;
  bit       quiet = 0;
  bit       hold_request = 0;
  int       hold_left = 0;

  // Sender: a new request goes out at the falling edge after the previous
  // one was accepted, with occasional random gaps in between.
  always @(negedge clk) begin
    if (!in_valid || req_taken) begin
      req_taken = 0;
      if (pending_reqs.size() == 0 || (!quiet && $urandom_range(0, 99) < 6)) begin
        in_valid <= 1'b0;
      end else begin
        cur_req = pending_reqs.pop_front();
        in_req <= cur_req.req;
        in_valid <= 1'b1;
      end
    end
  end

  // Receiver stall: random, plus one long hold-off that lets the block
  // fill up and push back on the sender.
  always @(negedge clk) begin
    if (hold_request && hold_left == 0) begin
      hold_request = 0;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && $urandom_range(0, 99) < 6;
    end
  end

  task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n && in_valid && !in_stall) begin
      predicted.push_back(cur_req.res);
      req_taken = 1;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (predicted.size() == 0) begin
        $display("%0t: result with none expected, got %0h", $time, out_res);
        errors++;
      end else begin
        exp_r = predicted.pop_front();
        results_checked++;
        check_field("read_data", exp_r.read_data, out_res.read_data);
        check_field("current_drive", 8'(exp_r.current_drive), 8'(out_res.current_drive));
        check_field("half_track", 8'(exp_r.half_track), 8'(out_res.half_track));
        check_field("track", 8'(exp_r.track), 8'(out_res.track));
        check_field("track_needed", 8'(exp_r.track_needed), 8'(out_res.track_needed));
        check_field("writeback_needed", 8'(exp_r.writeback_needed),
                    8'(out_res.writeback_needed));
        check_field("motor_on", 8'(exp_r.motor_on), 8'(out_res.motor_on));
        check_field("spinning_mask", 8'(exp_r.spinning_mask), 8'(out_res.spinning_mask));
        check_field("writing_mask", 8'(exp_r.writing_mask), 8'(out_res.writing_mask));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------
  function automatic item_t random_fields();
    logic [95:0] bits;
    bits = {$urandom(), $urandom(), $urandom()};
    return bits[65:0];
  endfunction

  // Queue a request with its prediction. A read of a never-written entry
  // is turned into a tick instead.
  task automatic queue_req(item_t it);
    request_t r;
    if (hits_blank_entry(it)) begin
      it.command = CMD_TICK;
      it.elapsed_cycles = 16'($urandom_range(0, 300));
    end
    r.req = it;
    r.res = controller_step(it);
    pending_reqs.push_back(r);
  endtask

  task automatic switch_req(logic [3:0] sw);
    item_t it;
    it = random_fields();
    it.command = CMD_SWITCH;
    it.addr_low[3:0] = sw;
    queue_req(it);
  endtask

  task automatic latch_write(logic [7:0] value);
    item_t it;
    it = random_fields();
    it.command = CMD_SWITCH;
    it.addr_low[3:0] = SW_LATCH;
    it.is_write = 1'b1;
    it.bus_data = value;
    queue_req(it);
  endtask

  task automatic tick_req(int unsigned cycles);
    item_t it;
    it = random_fields();
    it.command = CMD_TICK;
    it.elapsed_cycles = 16'(cycles);
    queue_req(it);
  endtask

  task automatic store_req(cmd_t cmd, bit drv, int unsigned idx, bit last);
    item_t it;
    it = random_fields();
    it.command = cmd;
    it.target_drive = drv;
    it.nibble_index = 13'(idx);
    it.last_nibble = last;
    queue_req(it);
  endtask

  // Stepper magnet access; phase 0..3, address bit 3 kept low.
  task automatic magnet_req(logic [1:0] phase, bit on);
    item_t it;
    it = random_fields();
    it.command = CMD_SWITCH;
    it.addr_low[3:0] = {1'b0, phase, on};
    queue_req(it);
  endtask

  task automatic load_track(bit drv, int unsigned n);
    for (int i = 0; i < n; i++) store_req(CMD_LOAD, drv, i, i == n - 1);
  endtask

  task automatic read_back_dirty();
    for (int d = 0; d < DRIVE_COUNT; d++) begin
      if (m_dirty[d] && m_count[d] != 0)
        for (int i = 0; i < m_count[d]; i++)
          store_req(CMD_READ, 1'(d), i, i == m_count[d] - 1);
    end
  endtask

  // Moves the selected head by energizing the neighbouring magnet.
  task automatic step_head(bit outward, int unsigned steps);
    logic [1:0] ph;
    for (int p = 0; p < 4; p++) magnet_req(2'(p), 1'b0);
    for (int s = 0; s < steps; s++) begin
      ph = 2'(outward ? (m_head[m_sel] + 1) % 4 : (m_head[m_sel] + 3) % 4);
      magnet_req(ph, 1'b1);
      magnet_req(ph, 1'b0);
    end
  endtask

  task automatic noise_req();
    item_t it;
    int unsigned r;
    it = random_fields();
    r = $urandom_range(0, 99);
    if (r < 45) begin
      it.command = CMD_SWITCH;
      if ($urandom_range(0, 2) == 0) it.addr_low[3:0] = SW_NIBBLE;
    end else if (r < 70) begin
      it.command = CMD_TICK;
      if ($urandom_range(0, 3) != 0) it.elapsed_cycles = 16'($urandom_range(0, 3000));
    end else if (r < 85) begin
      it.command = CMD_LOAD;
      if ($urandom_range(0, 3) != 0) it.nibble_index = 13'($urandom_range(0, 63));
    end else begin
      it.command = CMD_READ;
      if ($urandom_range(0, 3) != 0) it.nibble_index = 13'($urandom_range(0, 63));
    end
    queue_req(it);
  endtask

  // Read or write a burst of nibbles on the selected drive.
  task automatic nibble_burst();
    if ($urandom_range(0, 1)) begin
      latch_write({1'b1, 7'($urandom())});
      switch_req(SW_WRITE_MODE);
    end else begin
      switch_req(SW_READ_MODE);
    end
    for (int i = $urandom_range(2, 12); i > 0; i--) begin
      if ($urandom_range(0, 4) == 0) tick_req($urandom_range(0, 500));
      else switch_req(SW_NIBBLE);
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || predicted.size() != 0 || in_valid);
  endtask

  task automatic write_reg(cfg_idx_t idx, bit value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_LOADED0 || idx == CFG_LOADED1) begin
      m_loaded[idx] = value;
      if (!value) begin
        m_valid[idx] = 0;
        m_dirty[idx] = 0;
      end
    end else if (idx == CFG_PROTECTED0 || idx == CFG_PROTECTED1) begin
      m_protected[idx - CFG_PROTECTED0] = value;
    end else begin
      m_enhanced = value;
    end
  endtask

  task automatic apply_settings(bit [4:0] regs);
    write_reg(CFG_LOADED0, regs[0]);
    write_reg(CFG_LOADED1, regs[1]);
    write_reg(CFG_PROTECTED0, regs[2]);
    write_reg(CFG_PROTECTED1, regs[3]);
    write_reg(CFG_ENHANCED, regs[4]);
    settings_run++;
  endtask

  // ---------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------
  initial begin
    int unsigned added;
    bit [4:0] regs;
    m_enhanced = 1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: drive 0 writable, drive 1 protected, disk rotation on.
    apply_settings(5'b01011);
    switch_req(SW_NIBBLE);            // no track yet: 0xFF
    begin
      item_t it;
      it = random_fields();
      it.command = CMD_SWITCH;
      it.addr_low = STEPPER_E0;       // stepper access that reads 0xFF
      queue_req(it);
    end
    switch_req(SW_SELECT1);
    switch_req(SW_READ_MODE);         // protected drive reports bit 7 high
    switch_req(SW_SELECT0);
    switch_req(SW_MOTOR_ON);
    load_track(0, 4);
    switch_req(SW_NIBBLE);
    latch_write(8'h35);               // latch without bit 7: nothing stored
    switch_req(SW_WRITE_MODE);
    switch_req(SW_NIBBLE);
    latch_write(8'hD5);
    switch_req(SW_NIBBLE);            // marks drive 0 dirty
    step_head(1'b1, 1);               // leaving a dirty track
    store_req(CMD_LOAD, 0, 2, 1'b1);  // refused while dirty
    read_back_dirty();
    store_req(CMD_LOAD, 0, TRACK_BYTES, 1'b1);
    store_req(CMD_READ, 1, 8191, 1'b0);
    switch_req(SW_MOTOR_OFF);
    tick_req(65535);
    tick_req(0);
    wait_idle();

    // Random phases under changing settings, all-ones and all-zeros among them.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: regs = 5'b11111;
        1: regs = 5'b00000;
        2: regs = 5'b00011;
        default: begin
          regs = 5'($urandom());
          regs[1:0] |= ($urandom_range(0, 3) != 0) ? 2'b11 : 2'b00;
        end
      endcase
      apply_settings(regs);
      quiet = (ph == 4);
      if (ph == 5) hold_request = 1;
      added = pending_reqs.size();
      while (pending_reqs.size() - added < 125 && pending_reqs.size() < 400) begin
        case ($urandom_range(0, 9))
          0, 1: load_track($urandom_range(0, 1),
                           ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                       : $urandom_range(1, 40));
          2, 3, 4: nibble_burst();
          5: step_head($urandom_range(0, 1),
                       ($urandom_range(0, 7) == 0) ? 85 : $urandom_range(1, 4));
          6: begin
            switch_req($urandom_range(0, 1) ? SW_SELECT1 : SW_SELECT0);
            switch_req($urandom_range(0, 1) ? SW_MOTOR_ON : SW_MOTOR_OFF);
          end
          7: read_back_dirty();
          default: for (int i = 0; i < 4; i++) noise_req();
        endcase
        if (pending_reqs.size() > 200) @(posedge clk);
      end
      wait_idle();
    end
    quiet = 0;
    repeat (20) @(posedge clk);

    $display("Checked %0d results over %0d register settings,", results_checked,
             settings_run);
    $display("covering loads, read-backs, head steps, nibble access and ticks.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("Timed out waiting for results.");
    $display("Some tests failed");
    $finish;
  end

endmodule
